// ----- design/sorted_min_priority_queue_assert.svh -----
// Assertion macros used by the sorted priority queue RTL.
`ifndef SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

`define SMPQ_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("smpq assertion failed");

`define SMPQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("smpq assertion failed");

`else

`define SMPQ_ASSERT(label, clk, rstn, prop)

`define SMPQ_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- design/smpq_pkg.sv -----
// Shared types and constants of the sorted priority queue.
package smpq_pkg;

  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned PRIO_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 10;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    opcode_e                   opcode;
    logic [HANDLE_W-1:0]       handle;
    logic signed [PRIO_W-1:0]  prio;
  } cmd_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]       handle;
    logic signed [PRIO_W-1:0]  prio;
    status_e                   status;
    logic [COUNT_W-1:0]        count;
  } res_t;

endpackage

// ----- design/smpq_if.sv -----
// Request and response channel interfaces of the sorted priority queue.
interface smpq_req_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   opcode;
  logic [smpq_pkg::HANDLE_W-1:0]          entry_handle;
  logic signed [smpq_pkg::PRIO_W-1:0]     priority_req;

  modport source (output valid, opcode, entry_handle, priority_req, input ready);
  modport sink   (input valid, opcode, entry_handle, priority_req, output ready);
endinterface

interface smpq_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic [smpq_pkg::HANDLE_W-1:0]          out_handle;
  logic signed [smpq_pkg::PRIO_W-1:0]     out_priority;
  logic [smpq_pkg::STATUS_W-1:0]          status;
  logic [smpq_pkg::COUNT_W-1:0]           entry_count;

  modport source (output valid, out_handle, out_priority, status, entry_count, input ready);
  modport sink   (input valid, out_handle, out_priority, status, entry_count, output ready);
endinterface

// ----- design/sorted_min_priority_queue.sv -----
// Top level of the sorted minimum priority queue.
// Entries live in one ring-addressed RAM kept in ascending priority order; the head
// is the minimum. An extract reads the head and advances the ring pointer. An insert
// scans back from the tail with one shared comparator and moves each entry that must
// follow the new one up by one slot, one entry per cycle through the RAM's single read
// and single write port; when the new priority equals the last entry's, the head is
// read as well to decide between front and back. A refused insert, an extract from
// empty and an insert into an empty queue go from idle straight to done. The input
// is ready again once the result has moved into the output register; that register
// holds it until the sink takes the beat.
module sorted_min_priority_queue #(
  parameter int unsigned CAPACITY    = 512,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  smpq_req_if.sink    req_i,
  smpq_rsp_if.source  rsp_o
);

  import smpq_pkg::*;

  cmd_t cmd;
  res_t seq_res;
  res_t out_q;
  logic seq_ready;
  logic seq_res_valid;
  logic seq_res_ready;
  logic out_valid_q;

  assign cmd.opcode = opcode_e'(req_i.opcode);
  assign cmd.handle = req_i.entry_handle;
  assign cmd.prio   = req_i.priority_req;

  assign req_i.ready = seq_ready;

  smpq_seq #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (req_i.valid && seq_ready),
    .cmd_i       (cmd),
    .ready_o     (seq_ready),
    .res_valid_o (seq_res_valid),
    .res_ready_i (seq_res_ready),
    .res_o       (seq_res)
  );

  assign seq_res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_res_valid && seq_res_ready) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_res_valid && seq_res_ready) begin
      out_q <= seq_res;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.out_handle   = out_q.handle;
  assign rsp_o.out_priority = out_q.prio;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.entry_count  = out_q.count;

endmodule

// ----- design/smpq_ram.sv -----
// Generic simple dual-port RAM with registered read.
module smpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/smpq_seq.sv -----
// Sequencer, shared comparator and entry memory of the sorted priority queue.
`include "sorted_min_priority_queue_assert.svh"

module smpq_seq #(
  parameter int unsigned CAPACITY    = 512,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  smpq_pkg::cmd_t cmd_i,
  output logic           ready_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output smpq_pkg::res_t res_o
);

  import smpq_pkg::*;

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned SH_W   = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int unsigned DATA_W = PRIO_W + SH_W;
  localparam logic [ADDR_W:0]  CAP_L = (ADDR_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXTR = 6'b000010,
    S_SCAN = 6'b000100,
    S_HEAD = 6'b001000,
    S_PUT  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e                   state_q, state_d;
  logic [ADDR_W-1:0]        head_q, head_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     first_q, first_d;
  logic [ADDR_W-1:0]        idx_q, idx_d;
  logic signed [PRIO_W-1:0] key_q, key_d;
  logic [SH_W-1:0]          hnd_q, hnd_d;
  res_t                     res_q, res_d;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;

  logic signed [PRIO_W-1:0] rd_prio;
  logic [SH_W-1:0]          rd_hnd;
  logic                     key_lt;
  logic                     key_eq;
  logic                     do_shift;
  logic [CNT_W-1:0]         cnt_dec;
  logic [CNT_W-1:0]         cnt_inc;
  logic [ADDR_W-1:0]        idx_p1;
  logic [ADDR_W-1:0]        idx_m1;

  // ring address: head plus logical offset, modulo capacity
  function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] base,
                                             input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CAP_L) begin
      sum = sum - CAP_L;
    end
    return sum[ADDR_W-1:0];
  endfunction

  smpq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_prio = ram_rdata[DATA_W-1 -: PRIO_W];
  assign rd_hnd  = ram_rdata[SH_W-1:0];

  // shared comparator: stored priority against the new key
  assign key_lt   = rd_prio < key_q;
  assign key_eq   = rd_prio == key_q;
  assign do_shift = first_q ? (!key_lt && !key_eq) : !key_lt;

  assign cnt_dec = count_q - 1'b1;
  assign cnt_inc = count_q + 1'b1;
  assign idx_p1  = idx_q + 1'b1;
  assign idx_m1  = idx_q - 1'b1;

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    first_d   = first_q;
    idx_d     = idx_q;
    key_d     = key_q;
    hnd_d     = hnd_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = phys(head_q, idx_p1);
    ram_wdata = {key_q, hnd_q};
    ram_raddr = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          key_d        = cmd_i.prio;
          hnd_d        = cmd_i.handle[SH_W-1:0];
          res_d.handle = '0;
          res_d.prio   = '0;
          res_d.status = ST_OK;
          res_d.count  = COUNT_W'(count_q);
          if (cmd_i.opcode == OP_EXTRACT) begin
            if (count_q == '0) begin
              res_d.status = ST_EMPTY;
              state_d      = S_DONE;
            end else begin
              ram_raddr = head_q;
              state_d   = S_EXTR;
            end
          end else begin
            if (count_q == CAP_C) begin
              res_d.status = ST_FULL;
              state_d      = S_DONE;
            end else if (count_q == '0) begin
              ram_we      = 1'b1;
              ram_waddr   = head_q;
              ram_wdata   = {cmd_i.prio, cmd_i.handle[SH_W-1:0]};
              count_d     = cnt_inc;
              res_d.count = COUNT_W'(cnt_inc);
              state_d     = S_DONE;
            end else begin
              ram_raddr = phys(head_q, cnt_dec[ADDR_W-1:0]);
              idx_d     = cnt_dec[ADDR_W-1:0];
              first_d   = 1'b1;
              state_d   = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        first_d = 1'b0;
        ram_we  = 1'b1;
        if (do_shift) begin
          ram_wdata = ram_rdata;
          if (idx_q == '0) begin
            state_d = S_PUT;
          end else begin
            ram_raddr = phys(head_q, idx_m1);
            idx_d     = idx_m1;
          end
        end else if (first_q && key_eq) begin
          // tie with the tail: move it up, then let the head decide
          ram_wdata = ram_rdata;
          state_d   = S_HEAD;
        end else begin
          count_d     = cnt_inc;
          res_d.count = COUNT_W'(cnt_inc);
          state_d     = S_DONE;
        end
      end
      S_HEAD: begin
        if (!key_lt) begin
          // all entries equal the key: new entry goes to the front
          if (idx_q == '0) begin
            state_d = S_PUT;
          end else begin
            ram_raddr = phys(head_q, idx_m1);
            idx_d     = idx_m1;
            state_d   = S_SCAN;
          end
        end else begin
          ram_we      = 1'b1;
          count_d     = cnt_inc;
          res_d.count = COUNT_W'(cnt_inc);
          state_d     = S_DONE;
        end
      end
      S_PUT: begin
        ram_we      = 1'b1;
        ram_waddr   = phys(head_q, idx_q);
        count_d     = cnt_inc;
        res_d.count = COUNT_W'(cnt_inc);
        state_d     = S_DONE;
      end
      S_EXTR: begin
        res_d.handle = HANDLE_W'(rd_hnd);
        res_d.prio   = rd_prio;
        res_d.status = ST_OK;
        res_d.count  = COUNT_W'(cnt_dec);
        count_d      = cnt_dec;
        head_d       = phys(head_q, ADDR_W'(1));
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    key_q <= key_d;
    hnd_q <= hnd_d;
    res_q <= res_d;
  end

  assign ready_o     = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  `SMPQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CAP_C)
  `SMPQ_ASSERT(a_scan_idx, clk_i, rst_ni, (state_q != S_SCAN) || (CNT_W'(idx_q) < count_q))
  `SMPQ_ASSERT_NEXT(a_full_refused, clk_i, rst_ni,
                    state_q == S_IDLE && start_i && cmd_i.opcode == OP_INSERT && count_q == CAP_C,
                    state_q == S_DONE && res_q.status == ST_FULL && $stable(count_q))
  `SMPQ_ASSERT_NEXT(a_extract_dec, clk_i, rst_ni, state_q == S_EXTR,
                    count_q == $past(count_q) - 1'b1 && state_q == S_DONE)

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the sorted minimum priority queue: directed, fill, drain, random.
`timescale 1ns / 1ps

module tb_top;
  import smpq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 512;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RAND_ITEMS  = 70;
  localparam int unsigned DRAIN_ITEMS = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  smpq_req_if req_if ();
  smpq_rsp_if rsp_if ();

  sorted_min_priority_queue #(
    .CAPACITY   (QUEUE_DEPTH),
    .HANDLE_BITS(HANDLE_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  class sorted_queue_tracker;
    logic signed [PRIO_W-1:0] prio_list[$];
    logic [HANDLE_W-1:0]      handle_list[$];
    res_t                     pending_results[$];
    int unsigned              errors = 0;

    function void note_command(cmd_t c);
      res_t                     r;
      logic signed [PRIO_W-1:0] p;
      int                       n;
      int                       pos;
      r = '0;
      r.status = ST_OK;
      p = $signed(c.prio);
      n = prio_list.size();
      if (c.opcode == OP_INSERT) begin
        if (n >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (n == 0 || prio_list[0] >= p) begin
            pos = 0;
          end else if (prio_list[n-1] <= p) begin
            pos = n;
          end else begin
            pos = 1;
            while (prio_list[pos] < p) pos++;
          end
          prio_list.insert(pos, p);
          handle_list.insert(pos, c.handle);
        end
      end else begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.handle = handle_list.pop_front();
          r.prio   = prio_list.pop_front();
        end
      end
      r.count = COUNT_W'(prio_list.size());
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %0h", $time, got);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        compare_field("handle", 32'(exp_r.handle), 32'(got.handle));
        compare_field("priority", exp_r.prio, got.prio);
        compare_field("status", 32'(exp_r.status), 32'(got.status));
        compare_field("count", 32'(exp_r.count), 32'(got.count));
      end
    endfunction
  endclass

  sorted_queue_tracker tracker = new();

  int          sender_idle_pct = 0;
  int          recv_stall_pct  = 0;
  bit          hold_kick       = 1'b0;
  bit          hold_seen       = 1'b0;
  int unsigned hold_left       = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // long receiver hold-off, restarted on each toggle of hold_kick
  always @(posedge clk_i) begin
    hold_seen <= hold_kick;
    if (hold_kick != hold_seen) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin : rsp_side
    res_t got;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.handle = rsp_if.out_handle;
        got.prio   = rsp_if.out_priority;
        got.status = status_e'(rsp_if.status);
        got.count  = rsp_if.entry_count;
        tracker.check_result(got);
      end
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_cmd(opcode_e op, logic [HANDLE_W-1:0] h, logic signed [PRIO_W-1:0] p);
    cmd_t c;
    c.opcode = op;
    c.handle = h;
    c.prio   = p;
    while ($urandom_range(99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.opcode       <= op;
    req_if.entry_handle <= h;
    req_if.priority_req <= p;
    do @(posedge clk_i); while (!req_if.ready);
    tracker.note_command(c);
  endtask

  task automatic pop_min();
    push_cmd(OP_EXTRACT, HANDLE_W'($urandom), $urandom);
  endtask

  task automatic random_cmd(int insert_pct);
    logic signed [PRIO_W-1:0] p;
    logic [HANDLE_W-1:0]      h;
    int                       r;
    int                       n;
    n = tracker.prio_list.size();
    r = $urandom_range(99);
    if (r < 15 && n > 0) begin
      p = tracker.prio_list[$urandom_range(n - 1)];
    end else if (r < 25) begin
      case ($urandom_range(3))
        0:       p = 32'sh8000_0000;
        1:       p = 32'sh7FFF_FFFF;
        2:       p = '0;
        default: p = -1;
      endcase
    end else begin
      p = $urandom;
    end
    if ($urandom_range(19) == 0) begin
      h = $urandom_range(1) ? '1 : '0;
    end else begin
      h = HANDLE_W'($urandom);
    end
    push_cmd(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_EXTRACT, h, p);
  endtask

  task automatic set_idle(int send_pct, int recv_pct);
    sender_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  initial begin
    logic signed [PRIO_W-1:0] fill_prio;
    int                       modes_s[4];
    int                       modes_r[4];
    modes_s = '{0, 81, 0, 29};
    modes_r = '{0, 0, 81, 29};

    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.opcode       <= OP_INSERT;
    req_if.entry_handle <= '0;
    req_if.priority_req <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty, extremes, ties at head, tail and middle
    set_idle(0, 0);
    pop_min();
    push_cmd(OP_INSERT, 16'h0000, 32'sh0000_0000);
    push_cmd(OP_INSERT, 16'hFFFF, 32'sh7FFF_FFFF);
    push_cmd(OP_INSERT, 16'h1234, 32'sh8000_0000);
    push_cmd(OP_INSERT, 16'h0001, 32'sh8000_0000);
    push_cmd(OP_INSERT, 16'h0002, 32'sh7FFF_FFFF);
    push_cmd(OP_INSERT, 16'h0003, 32'sh0000_0000);
    push_cmd(OP_INSERT, 16'h0004, 32'shFFFF_FFFF);
    push_cmd(OP_INSERT, 16'h0005, 32'sh0001_0000);
    push_cmd(OP_INSERT, 16'hA5A5, 32'shFFFF_0000);
    repeat (10) pop_min();

    // random mix: the queue grows, then shrinks, in each phase
    for (int m = 0; m < 4; m++) begin
      set_idle(modes_s[m], modes_r[m]);
      for (int i = 0; i < RAND_ITEMS; i++) begin
        if (m == 0 && i == 60) hold_kick <= ~hold_kick;
        random_cmd((i < RAND_ITEMS * 3 / 5) ? 70 : 30);
      end
    end

    // fill to capacity in rising order, refuse, refill, then drain part
    set_idle(29, 29);
    fill_prio = 32'sh8000_0000 + $urandom_range(16'hFFFF);
    while (tracker.prio_list.size() < QUEUE_DEPTH) begin
      push_cmd(OP_INSERT, HANDLE_W'($urandom), fill_prio);
      if ($urandom_range(9) != 0) fill_prio = fill_prio + $urandom_range(32'h003F_FFFF);
    end
    push_cmd(OP_INSERT, 16'h0000, 32'sh8000_0000);
    push_cmd(OP_INSERT, 16'hFFFF, 32'sh7FFF_FFFF);
    push_cmd(OP_INSERT, HANDLE_W'($urandom), $urandom);
    repeat (3) pop_min();
    repeat (3) push_cmd(OP_INSERT, HANDLE_W'($urandom), $urandom);
    repeat (2) push_cmd(OP_INSERT, HANDLE_W'($urandom), $urandom);
    repeat (DRAIN_ITEMS) pop_min();
    req_if.valid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
